// ===== rtl/mec_pkg.sv =====
package mec_pkg;

	// coordinate format
	localparam int unsigned COORD_W = 32;
	localparam int unsigned FRAC_W  = 28;
	localparam int unsigned ITER_W  = 16;

	// datapath widths
	localparam int unsigned PROD_W = 2 * COORD_W;
	localparam int unsigned DIFF_W = PROD_W + 1;
	localparam int unsigned SUM_W  = DIFF_W + 1;

	// escape limits: component bound 2.0 and squared magnitude bound 4.0
	localparam logic signed [SUM_W-1:0]  BOUND   = SUM_W'(2) << FRAC_W;
	localparam logic signed [DIFF_W-1:0] MAG_LIM = DIFF_W'(1) << (2 * FRAC_W + 2);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ITER_W-1:0] iter_t;

	typedef struct packed {
		coord_t c_re;
		coord_t c_im;
	} in_t;

	typedef struct packed {
		iter_t iter_count;
		logic  in_set;
	} out_t;

	// engine status toward the top level
	typedef struct packed {
		logic  fin;
		iter_t count;
	} stat_t;

endpackage

// ===== rtl/mec_engine.sv =====
module mec_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  mec_pkg::in_t   c,
	input  mec_pkg::iter_t max_iter,
	output mec_pkg::stat_t stat
);
	import mec_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RR   = 3'd1;
	localparam logic [2:0] S_II   = 3'd2;
	localparam logic [2:0] S_RI   = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	logic [2:0] state_q;
	logic       chk_q;
	iter_t      pass_q;

	coord_t cre_q, cim_q, re_q, im_q;
	logic signed [PROD_W-1:0] prod_q, rr_q;
	logic signed [DIFF_W-1:0] diff_q;

	coord_t mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [DIFF_W-1:0] mag;
	logic signed [SUM_W-1:0]  nr, ni;
	logic mag_esc, bnd_esc;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_II: begin
				mul_a = im_q;
				mul_b = im_q;
			end
			S_RI: begin
				mul_a = re_q;
				mul_b = im_q;
			end
			default: begin
				mul_a = re_q;
				mul_b = re_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// squared magnitude of the previous pass result (prod_q holds im*im here)
	assign mag = $signed({rr_q[PROD_W-1], rr_q}) + $signed({prod_q[PROD_W-1], prod_q});
	assign mag_esc = chk_q && (mag > MAG_LIM);

	// new orbit point, floor shifts (prod_q holds re*im here)
	assign nr = ($signed({diff_q[DIFF_W-1], diff_q}) >>> FRAC_W)
		+ $signed({{(SUM_W-COORD_W){cre_q[COORD_W-1]}}, cre_q});
	assign ni = ($signed({{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}) >>> (FRAC_W - 1))
		+ $signed({{(SUM_W-COORD_W){cim_q[COORD_W-1]}}, cim_q});
	assign bnd_esc = (nr > BOUND) || (nr < -BOUND) || (ni > BOUND) || (ni < -BOUND);

	// finish: magnitude escape belongs to the previous pass
	always_comb begin
		stat.fin   = 1'b0;
		stat.count = pass_q;
		if (state_q == S_RI && mag_esc) begin
			stat.fin   = 1'b1;
			stat.count = pass_q - ITER_W'(1);
		end else if (state_q == S_UPD && (bnd_esc || pass_q == max_iter)) begin
			stat.fin = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chk_q   <= 1'b0;
			pass_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						state_q <= S_RR;
						chk_q   <= 1'b0;
						pass_q  <= '0;
					end
				end
				S_RR: state_q <= S_II;
				S_II: state_q <= S_RI;
				S_RI: state_q <= mag_esc ? S_IDLE : S_UPD;
				S_UPD: begin
					if (stat.fin) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RR;
						chk_q   <= 1'b1;
						pass_q  <= pass_q + ITER_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && go) begin
			cre_q <= c.c_re;
			cim_q <= c.c_im;
			re_q  <= c.c_re;
			im_q  <= c.c_im;
		end
		if (state_q == S_RR || state_q == S_II || state_q == S_RI) begin
			prod_q <= prod;
		end
		if (state_q == S_II) begin
			rr_q <= prod_q;
		end
		if (state_q == S_RI) begin
			diff_q <= $signed({rr_q[PROD_W-1], rr_q}) - $signed({prod_q[PROD_W-1], prod_q});
		end
		if (state_q == S_UPD) begin
			re_q <= nr[COORD_W-1:0];
			im_q <= ni[COORD_W-1:0];
		end
	end

endmodule

// ===== rtl/mandelbrot_escape_count.sv =====
// Escape-time counter for one point c of the complex plane, Q4.28 coordinates.
// Input beat: drive c and raise start; the point is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// Result beat: done is high for exactly one cycle with res valid in that cycle.
// The receiver cannot stall; a result must be taken in its cycle.
// The orbit starts at z = c; each pass forms z*z + c and escapes when a part
// leaves [-2, 2] or |z|^2 > 4. res.iter_count is the escape pass or max_iter,
// and res.in_set is high when the count equals max_iter.
// Each pass steps through one shared 32x32 multiplier: re*re, im*im, re*im
// and an update step. The run ends in the update step when a part leaves
// [-2, 2], and in the re*im step of the next pass when |z|^2 > 4; points in
// the set end in the update step of the pass whose count equals max_iter.
// A new point may be started in the same cycle that done is high.
// cfg_we writes max_iter from cfg_wdata; write it only while idle.
// Reset clears the sequencer, drops busy and done, and sets max_iter to 255.
module mandelbrot_escape_count (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  mec_pkg::in_t            c,
	output logic                    done,
	output mec_pkg::out_t           res,
	input  logic                    cfg_we,
	input  logic [mec_pkg::ITER_W-1:0] cfg_wdata
);
	import mec_pkg::*;

	logic  busy_q, done_q;
	iter_t max_iter_q;
	out_t  res_q;
	stat_t stat;
	logic  accept;

	assign accept = start && !busy_q;

	mec_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept),
		.c        (c),
		.max_iter (max_iter_q),
		.stat     (stat)
	);

	// iteration limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= ITER_W'(255);
		end else if (cfg_we) begin
			max_iter_q <= cfg_wdata;
		end
	end

	// busy flag and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= stat.fin;
			if (stat.fin) begin
				busy_q <= 1'b0;
			end else if (accept) begin
				busy_q <= 1'b1;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (stat.fin) begin
			res_q.iter_count <= stat.count;
			res_q.in_set     <= (stat.count == max_iter_q);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;

	// an accepted point keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy_q)
		else $error("busy not raised after accept");

	// a result beat ends the busy period
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("busy still high with result beat");

	// results come only out of a busy period
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("result beat without a point in flight");

endmodule
